FILE: rtl/asdm_pkg.sv
// Shared constants and types of the analog stick dead-zone mapper.
package asdm_pkg;

  localparam int NUM_STICKS  = 2;
  localparam int STICK_IDX_W = (NUM_STICKS > 1) ? $clog2(NUM_STICKS) : 1;
  localparam int ONE_Q14     = 16384;

  localparam int VAL_W      = 16;
  localparam int MAG_W      = 15;
  localparam int DZ_W       = 14;
  localparam int LVL_W      = 15;
  localparam int DEV_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  localparam int DIV_NUM_W = 31;
  localparam int DIV_DEN_W = 15;
  localparam int RAD_W     = 30;
  localparam int ROOT_W    = 15;
  localparam int OPND_W    = 17;
  localparam int PROD_W    = 34;
  localparam int RES_W     = 33;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEAD_ZONE = 2'd0,
    CFG_INV_DZ    = 2'd1,
    CFG_SENS      = 2'd2,
    CFG_CIRC      = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

FILE: rtl/asdm_div.sv
// Shared restoring divider, one quotient bit per cycle.
module asdm_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  asdm_pkg::div_req_t              req_i,
  output asdm_pkg::unit_stat_t            stat_o,
  output logic [asdm_pkg::DIV_NUM_W-1:0]  quot_o
);

  localparam int CNT_W = $clog2(asdm_pkg::DIV_NUM_W);

  logic                             busy_q, done_q;
  logic [CNT_W-1:0]                 cnt_q;
  logic [asdm_pkg::DIV_NUM_W-1:0]   acc_q;
  logic [asdm_pkg::DIV_DEN_W-1:0]   rem_q, den_q, rem_d;
  logic [asdm_pkg::DIV_DEN_W:0]     trial, diff;
  logic                             ge;

  always_comb begin
    trial = {rem_q, acc_q[asdm_pkg::DIV_NUM_W-1]};
    ge    = trial >= {1'b0, den_q};
    diff  = trial - {1'b0, den_q};
    rem_d = ge ? diff[asdm_pkg::DIV_DEN_W-1:0] : trial[asdm_pkg::DIV_DEN_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      acc_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
    end else begin
      done_q <= !start_i && busy_q && (cnt_q == CNT_W'(asdm_pkg::DIV_NUM_W - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        acc_q  <= req_i.num;
        rem_q  <= '0;
        den_q  <= req_i.den;
      end else if (busy_q) begin
        rem_q <= rem_d;
        acc_q <= {acc_q[asdm_pkg::DIV_NUM_W-2:0], ge};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(asdm_pkg::DIV_NUM_W - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = acc_q;

endmodule

FILE: rtl/asdm_sqrt.sv
// Iterative rounded integer square root, two radicand bits per cycle.
module asdm_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [asdm_pkg::RAD_W-1:0]    rad_i,
  output asdm_pkg::unit_stat_t          stat_o,
  output logic [asdm_pkg::ROOT_W-1:0]   root_o
);

  logic                         busy_q, done_q;
  logic [asdm_pkg::RAD_W-1:0]   v_q, r_q, bit_q, sum, r_rnd;

  always_comb begin
    sum   = r_q + bit_q;
    r_rnd = (v_q > r_q) ? r_q + 1'b1 : r_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      v_q    <= '0;
      r_q    <= '0;
      bit_q  <= '0;
    end else begin
      done_q <= !start_i && busy_q && (bit_q == asdm_pkg::RAD_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        v_q    <= rad_i;
        r_q    <= '0;
        bit_q  <= asdm_pkg::RAD_W'(1) << (asdm_pkg::RAD_W - 2);
      end else if (busy_q) begin
        if (v_q >= sum) begin
          v_q <= v_q - sum;
          r_q <= (r_q >> 1) + bit_q;
        end else begin
          r_q <= r_q >> 1;
        end
        bit_q <= bit_q >> 2;
        if (bit_q == asdm_pkg::RAD_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign root_o      = r_rnd[asdm_pkg::ROOT_W-1:0];

endmodule

FILE: rtl/analog_stick_deadzone_mapper_top.sv
// Top level of the analog stick dead-zone mapper: stick state, sequencer and result register.
//
// One input beat carries one axis sample (stick, axis, Q2.14 value, source device) and
// produces exactly one output beat with the raw pair and the mapped pair of that stick.
// Configuration registers (dead zone, inverse dead zone, sensitivity, circular mode) are
// written through cfg_we_i, cfg_idx_i and cfg_data_i and take effect at once.
// The block takes one beat at a time: in_ready_o is high only while it is idle.
// A sample that is ignored, or a stick at rest, goes from idle straight to the output state.
// A mapped sample uses the shared 31-step divider three times (level, X, Y), and in
// circular mode it first uses the 15-step square root unit.
// The result stays in the output register until out_ready_i is taken; a stalled receiver
// simply holds the block, and no new beat is accepted until the result leaves.
// Reset clears both stick positions and owners and loads the default registers
// (sensitivity 1.0, all others zero).
module analog_stick_deadzone_mapper_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              stick_sel_i,
  input  logic                              axis_sel_i,
  input  logic signed [asdm_pkg::VAL_W-1:0] axis_value_i,
  input  logic [asdm_pkg::DEV_W-1:0]        source_device_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              stick_out_o,
  output logic signed [asdm_pkg::VAL_W-1:0] raw_x_o,
  output logic signed [asdm_pkg::VAL_W-1:0] raw_y_o,
  output logic signed [asdm_pkg::VAL_W-1:0] mapped_x_o,
  output logic signed [asdm_pkg::VAL_W-1:0] mapped_y_o,
  output logic                              mapped_valid_o,
  input  logic                              cfg_we_i,
  input  logic [asdm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [asdm_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_NORM, ST_SQRT, ST_MUL, ST_DIV, ST_WAIT, ST_OUT
  } state_e;

  typedef enum logic [1:0] {PH_LEVEL, PH_X, PH_Y} phase_e;

  localparam int VW = asdm_pkg::VAL_W;
  localparam int MW = asdm_pkg::MAG_W;

  state_e state_q;
  phase_e phase_q;

  logic [asdm_pkg::DZ_W-1:0]  dz_q;
  logic [asdm_pkg::LVL_W-1:0] inv_q, sens_q;
  logic                       circ_q;

  logic signed [VW-1:0]       pos_q [asdm_pkg::NUM_STICKS][2];
  logic [asdm_pkg::DEV_W-1:0] owner_q [asdm_pkg::NUM_STICKS];

  logic signed [VW-1:0]            x_q, y_q, raw_x_q, raw_y_q, mx_q, my_q;
  logic [MW-1:0]                   ax_q, ay_q, m_q, mn_q, norm_q;
  logic                            stick_q, valid_q, neg_q;
  logic signed [asdm_pkg::PROD_W-1:0] prod_q;
  logic [asdm_pkg::DIV_DEN_W-1:0]  den_q;

  // Accept-side logic.
  logic                            accept, in_range, in_dz, take;
  logic [asdm_pkg::STICK_IDX_W-1:0] idx;
  logic signed [VW-1:0]            v, cur_x, cur_y, new_x, new_y;
  logic [MW-1:0]                   av, nax, nay, nm;

  always_comb begin
    accept   = in_valid_i && in_ready_o;
    idx      = asdm_pkg::STICK_IDX_W'(stick_sel_i);
    in_range = int'(stick_sel_i) < asdm_pkg::NUM_STICKS;
    if (axis_value_i > VW'(asdm_pkg::ONE_Q14)) begin
      v = VW'(asdm_pkg::ONE_Q14);
    end else if (axis_value_i < -VW'(asdm_pkg::ONE_Q14)) begin
      v = -VW'(asdm_pkg::ONE_Q14);
    end else begin
      v = axis_value_i;
    end
    av     = v[VW-1] ? MW'(-v) : MW'(v);
    in_dz  = (19'(av) * 19'd10) < (19'(dz_q) * 19'd7);
    cur_x  = in_range ? pos_q[idx][0] : '0;
    cur_y  = in_range ? pos_q[idx][1] : '0;
    new_x  = axis_sel_i ? cur_x : v;
    new_y  = axis_sel_i ? v : cur_y;
    take   = in_range && !(in_dz && (owner_q[idx] != source_device_i));
    nax    = new_x[VW-1] ? MW'(-new_x) : MW'(new_x);
    nay    = new_y[VW-1] ? MW'(-new_y) : MW'(new_y);
    nm     = (nax > nay) ? nax : nay;
  end

  // Shared units.
  asdm_pkg::div_req_t             div_req;
  asdm_pkg::unit_stat_t           div_stat, sqrt_stat;
  logic [asdm_pkg::DIV_NUM_W-1:0] quot;
  logic [asdm_pkg::ROOT_W-1:0]    root;
  logic                           div_start, sqrt_start;
  logic [asdm_pkg::RAD_W-1:0]     rad;
  logic [asdm_pkg::PROD_W-1:0]    prod_mag;

  always_comb begin
    prod_mag    = prod_q[asdm_pkg::PROD_W-1] ? asdm_pkg::PROD_W'(-prod_q)
                                             : asdm_pkg::PROD_W'(prod_q);
    div_req.num = prod_mag[asdm_pkg::DIV_NUM_W-1:0]
                + asdm_pkg::DIV_NUM_W'(den_q >> 1);
    div_req.den = den_q;
    div_start   = (state_q == ST_DIV);
    sqrt_start  = (state_q == ST_NORM) && circ_q;
    rad         = (asdm_pkg::RAD_W'(ax_q) * asdm_pkg::RAD_W'(ax_q))
                + (asdm_pkg::RAD_W'(ay_q) * asdm_pkg::RAD_W'(ay_q));
  end

  asdm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .req_i   (div_req),
    .stat_o  (div_stat),
    .quot_o  (quot)
  );

  asdm_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (rad),
    .stat_o  (sqrt_stat),
    .root_o  (root)
  );

  // Multiplier operands and divider result handling.
  logic signed [asdm_pkg::OPND_W-1:0] op_a, op_b;
  logic [asdm_pkg::DIV_DEN_W-1:0]     den_n;
  logic signed [asdm_pkg::RES_W-1:0]  res, lvl;
  logic [MW-1:0]                      mn_n;
  logic signed [VW-1:0]               ax_res;

  always_comb begin
    case (phase_q)
      PH_LEVEL: begin
        op_a  = $signed({2'b00, norm_q}) - $signed({3'b000, dz_q});
        op_b  = $signed({2'b00, sens_q}) - $signed({2'b00, inv_q});
        den_n = asdm_pkg::DIV_DEN_W'(asdm_pkg::ONE_Q14) - asdm_pkg::DIV_DEN_W'(dz_q);
      end
      PH_X: begin
        op_a  = asdm_pkg::OPND_W'(x_q);
        op_b  = $signed({2'b00, mn_q});
        den_n = m_q;
      end
      default: begin
        op_a  = asdm_pkg::OPND_W'(y_q);
        op_b  = $signed({2'b00, mn_q});
        den_n = m_q;
      end
    endcase
    res = neg_q ? -$signed({2'b00, quot}) : $signed({2'b00, quot});
    lvl = $signed({{(asdm_pkg::RES_W - asdm_pkg::LVL_W){1'b0}}, inv_q}) + res;
    if (lvl < 0) begin
      mn_n = '0;
    end else if (lvl > asdm_pkg::RES_W'(asdm_pkg::ONE_Q14)) begin
      mn_n = MW'(asdm_pkg::ONE_Q14);
    end else begin
      mn_n = lvl[MW-1:0];
    end
    if (res > asdm_pkg::RES_W'(asdm_pkg::ONE_Q14)) begin
      ax_res = VW'(asdm_pkg::ONE_Q14);
    end else if (res < -asdm_pkg::RES_W'(asdm_pkg::ONE_Q14)) begin
      ax_res = -VW'(asdm_pkg::ONE_Q14);
    end else begin
      ax_res = res[VW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_LEVEL;
      dz_q    <= '0;
      inv_q   <= '0;
      sens_q  <= asdm_pkg::LVL_W'(asdm_pkg::ONE_Q14);
      circ_q  <= 1'b0;
      for (int i = 0; i < asdm_pkg::NUM_STICKS; i++) begin
        pos_q[i][0] <= '0;
        pos_q[i][1] <= '0;
        owner_q[i]  <= '0;
      end
      x_q     <= '0;
      y_q     <= '0;
      raw_x_q <= '0;
      raw_y_q <= '0;
      mx_q    <= '0;
      my_q    <= '0;
      ax_q    <= '0;
      ay_q    <= '0;
      m_q     <= '0;
      mn_q    <= '0;
      norm_q  <= '0;
      stick_q <= 1'b0;
      valid_q <= 1'b0;
      neg_q   <= 1'b0;
      prod_q  <= '0;
      den_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (asdm_pkg::cfg_idx_e'(cfg_idx_i))
          asdm_pkg::CFG_DEAD_ZONE: dz_q   <= cfg_data_i[asdm_pkg::DZ_W-1:0];
          asdm_pkg::CFG_INV_DZ:    inv_q  <= cfg_data_i;
          asdm_pkg::CFG_SENS:      sens_q <= cfg_data_i;
          asdm_pkg::CFG_CIRC:      circ_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            stick_q <= stick_sel_i;
            raw_x_q <= new_x;
            raw_y_q <= new_y;
            x_q     <= new_x;
            y_q     <= new_y;
            ax_q    <= nax;
            ay_q    <= nay;
            m_q     <= nm;
            mx_q    <= '0;
            my_q    <= '0;
            valid_q <= take;
            phase_q <= PH_LEVEL;
            if (in_range && !in_dz) begin
              owner_q[idx] <= source_device_i;
            end
            if (take) begin
              pos_q[idx][axis_sel_i] <= v;
            end
            state_q <= (take && (nm != '0)) ? ST_NORM : ST_OUT;
          end
        end
        ST_NORM: begin
          if (circ_q) begin
            state_q <= ST_SQRT;
          end else begin
            norm_q  <= m_q;
            state_q <= ST_MUL;
          end
        end
        ST_SQRT: begin
          if (sqrt_stat.done) begin
            norm_q  <= root;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod_q  <= asdm_pkg::PROD_W'(op_a) * asdm_pkg::PROD_W'(op_b);
          neg_q   <= op_a[asdm_pkg::OPND_W-1] ^ op_b[asdm_pkg::OPND_W-1];
          den_q   <= den_n;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          state_q <= ST_WAIT;
        end
        ST_WAIT: begin
          if (div_stat.done) begin
            case (phase_q)
              PH_LEVEL: begin
                mn_q    <= mn_n;
                phase_q <= PH_X;
                state_q <= ST_MUL;
              end
              PH_X: begin
                mx_q    <= ax_res;
                phase_q <= PH_Y;
                state_q <= ST_MUL;
              end
              default: begin
                my_q    <= ax_res;
                state_q <= ST_OUT;
              end
            endcase
          end
        end
        ST_OUT: begin
          if (out_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o     = (state_q == ST_IDLE);
  assign out_valid_o    = (state_q == ST_OUT);
  assign stick_out_o    = stick_q;
  assign raw_x_o        = raw_x_q;
  assign raw_y_o        = raw_y_q;
  assign mapped_x_o     = mx_q;
  assign mapped_y_o     = my_q;
  assign mapped_valid_o = valid_q;

  // The block never offers a result while it takes a new beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("ready and result valid at once");

  // An accepted beat takes in_ready_o low; the design keeps it low until the result has left.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken twice in a row");

  // An ignored sample reports a zero mapped pair.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !mapped_valid_o) |-> (mapped_x_o == '0 && mapped_y_o == '0))
    else $error("ignored sample has nonzero mapped pair");

  // The mapped level stays within full scale.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mn_q <= MW'(asdm_pkg::ONE_Q14))
    else $error("mapped level out of range");

  // The divider is only started when it is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  // The square root unit is only started when it is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sqrt_start |-> !sqrt_stat.busy)
    else $error("square root started while busy");

endmodule
